/* rtl/wse_pkg.sv */
// Shared constants, item and multiplier handshake types for the wyhash stream engine.
`timescale 1ns / 1ps

package wse_pkg;

   localparam int WORD_BYTES   = 8;
   localparam int WINDOW_BYTES = 64;
   localparam int QUEUE_DEPTH  = 2;
   localparam int BACK_W       = 6;

   localparam logic [5:0] CHUNK_BYTES = 6'd48;
   localparam logic [5:0] PAIR_BYTES  = 6'd16;
   localparam logic [5:0] LANE_STEP   = 6'd8;

   localparam logic [63:0] SEC0 = 64'ha0761d6478bd642f;
   localparam logic [63:0] SEC1 = 64'he7037ed1a0b428db;
   localparam logic [63:0] SEC2 = 64'h8ebc6af09c88c6e3;
   localparam logic [63:0] SEC3 = 64'h589965cc75374cc3;

   // One classified message word as it travels from the front end to the back end.
   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_word;
      logic        short_word;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mix_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } mix_rsp_type;

endpackage

/* rtl/wse_front.sv */
// Front end: accepts message words, clamps the byte count, flags short words, queues them.
`timescale 1ns / 1ps

module wse_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [63:0]        req_data_word,
   input  logic [3:0]         req_byte_count,
   input  logic               req_last_word,
   output logic               item_valid,
   output wse_pkg::item_type  item,
   input  logic               item_pop
);

   localparam int QP_W = $clog2(wse_pkg::QUEUE_DEPTH);
   localparam int QC_W = $clog2(wse_pkg::QUEUE_DEPTH + 1);

   wse_pkg::item_type q_ff [wse_pkg::QUEUE_DEPTH];
   logic [QP_W-1:0]   head_ff, head_in;
   logic [QP_W-1:0]   tail_ff, tail_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;
   wse_pkg::item_type new_item;
   logic              push;
   logic              pop;

   assign req_stall  = (cnt_ff == QC_W'(wse_pkg::QUEUE_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[head_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;

   always_comb begin
      new_item.data_word  = req_data_word;
      new_item.byte_count = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      new_item.last_word  = req_last_word;
      // A word short of eight bytes is only legal at the end of a message.
      new_item.short_word = !req_last_word && (new_item.byte_count < 4'd8);
   end

   always_comb begin
      head_in = pop  ? head_ff + QP_W'(1) : head_ff;
      tail_in = push ? tail_ff + QP_W'(1) : tail_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QC_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

/* rtl/wse_mix.sv */
// Mix unit: 64x64 product over four 32x32 partial products, low and high halves XORed.
`timescale 1ns / 1ps

module wse_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  wse_pkg::mix_req_type mix_req,
   output wse_pkg::mix_rsp_type mix_rsp
);

   logic [63:0]  a_ff, b_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  p_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [63:0]  value_ff;
   logic [31:0]  a_half, b_half;
   logic [127:0] addend;
   logic [127:0] acc_sum;

   assign mix_rsp.done  = done_ff;
   assign mix_rsp.value = value_ff;

   always_comb begin
      a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (sh_ff)
         2'd0:    addend = {64'd0, p_ff};
         2'd1:    addend = {32'd0, p_ff, 32'd0};
         default: addend = {p_ff, 64'd0};
      endcase
      acc_sum = acc_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (mix_req.start && !busy_ff) begin
         a_ff   <= mix_req.a;
         b_ff   <= mix_req.b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            p_ff  <= a_half * b_half;
            sh_ff <= 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
         end
         if (cnt_ff != 3'd0) begin
            acc_ff <= acc_sum;
         end
         if (cnt_ff == 3'd4) begin
            value_ff <= acc_sum[63:0] ^ acc_sum[127:64];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mix_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

/* rtl/wse_back.sv */
// Back end: byte window in eight banks, chunk lanes, tail sequencing and the result register.
`timescale 1ns / 1ps

module wse_back #(
   parameter int WINDOW_BYTES = wse_pkg::WINDOW_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  wse_pkg::item_type    item,
   output logic                 item_pop,
   output wse_pkg::mix_req_type mix_req,
   input  wse_pkg::mix_rsp_type mix_rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_hash_value,
   output logic [63:0]          rsp_message_length,
   output logic                 rsp_format_error
);

   localparam int PTR_W = $clog2(WINDOW_BYTES);
   localparam int DEPTH = WINDOW_BYTES / wse_pkg::WORD_BYTES;
   localparam int BA_W  = $clog2(DEPTH);
   localparam int BW    = wse_pkg::BACK_W;

   typedef enum logic [14:0] {
      S_IDLE      = 15'b000000000000001,
      S_WRITE     = 15'b000000000000010,
      S_CHK_RD    = 15'b000000000000100,
      S_CHK_GO    = 15'b000000000001000,
      S_CHK_WAIT  = 15'b000000000010000,
      S_FIN       = 15'b000000000100000,
      S_TAIL_RD   = 15'b000000001000000,
      S_TAIL_GO   = 15'b000000010000000,
      S_TAIL_WAIT = 15'b000000100000000,
      S_FR1       = 15'b000001000000000,
      S_FR2       = 15'b000010000000000,
      S_FR3       = 15'b000100000000000,
      S_MUL1_WAIT = 15'b001000000000000,
      S_MUL2_WAIT = 15'b010000000000000,
      S_OUT       = 15'b100000000000000
   } state_type;

   state_type         state_ff, state_in;
   wse_pkg::item_type cur_ff, cur_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [BW-1:0]     pend_ff, pend_in;
   logic [63:0]       len_ff, len_in;
   logic              err_ff, err_in;
   logic              chunk_ff, chunk_in;
   logic [63:0]       main_seed_ff, main_seed_in;
   logic [63:0]       lane1_seed_ff, lane1_seed_in;
   logic [63:0]       lane2_seed_ff, lane2_seed_in;
   logic [1:0]        lane_ff, lane_in;
   logic [BW-1:0]     tail_back_ff, tail_back_in;
   logic [63:0]       hold_a_ff, hold_a_in;
   logic [63:0]       hold_b_ff, hold_b_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_hash_ff, rsp_hash_in;
   logic [63:0]       rsp_len_ff, rsp_len_in;
   logic              rsp_err_ff, rsp_err_in;

   logic [BW-1:0]     back_a, back_b;
   logic [PTR_W-1:0]  start_a, start_b;
   logic [2:0]        rot_a_ff, rot_b_ff;
   logic [7:0]        rd_a_ff [wse_pkg::WORD_BYTES];
   logic [7:0]        rd_b_ff [wse_pkg::WORD_BYTES];
   logic [63:0]       rdata_a, rdata_b;
   logic              bank_we [wse_pkg::WORD_BYTES];
   logic [BA_W-1:0]   bank_wa [wse_pkg::WORD_BYTES];
   logic [7:0]        bank_wd [wse_pkg::WORD_BYTES];
   logic [BA_W-1:0]   bank_ra_a [wse_pkg::WORD_BYTES];
   logic [BA_W-1:0]   bank_ra_b [wse_pkg::WORD_BYTES];

   logic [4:0]        short_len;
   logic [4:0]        short_q;
   logic              is_short;
   logic [PTR_W:0]    wr_sum;
   logic [BW-1:0]     pend_sum;
   logic [63:0]       fin_a, fin_b;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hash_value     = rsp_hash_ff;
   assign rsp_message_length = rsp_len_ff;
   assign rsp_format_error   = rsp_err_ff;

   // Window position of the byte that lies 'back' bytes before the write pointer.
   function automatic logic [PTR_W-1:0] win_start(input logic [PTR_W-1:0] wp,
                                                  input logic [BW-1:0] back);
      logic [PTR_W:0] diff;
      diff = {1'b0, wp} + (PTR_W+1)'(WINDOW_BYTES) - (PTR_W+1)'(back);
      if ({1'b0, wp} >= (PTR_W+1)'(back)) begin
         diff = {1'b0, wp} - (PTR_W+1)'(back);
      end
      return diff[PTR_W-1:0];
   endfunction

   // Row in bank k that holds one of the eight bytes starting at window position pos.
   function automatic logic [BA_W-1:0] bank_addr(input logic [PTR_W-1:0] pos,
                                                 input logic [2:0] k);
      logic [BA_W:0] row;
      row = {1'b0, pos[PTR_W-1:3]} + (BA_W+1)'(k < pos[2:0]);
      if (row == (BA_W+1)'(DEPTH)) begin
         row = '0;
      end
      return row[BA_W-1:0];
   endfunction

   assign short_len = len_ff[4:0];
   assign short_q   = {1'b0, short_len[4:3], 2'b00};
   assign is_short  = (len_ff <= 64'd16);

   // Read addresses for the two window ports.
   always_comb begin
      back_a = '0;
      back_b = '0;
      case (state_ff)
         S_CHK_RD: begin
            back_a = pend_ff - {lane_ff, 4'b0000};
            back_b = pend_ff - {lane_ff, 4'b0000} - wse_pkg::LANE_STEP;
         end
         S_TAIL_RD: begin
            back_a = tail_back_ff;
            back_b = tail_back_ff - wse_pkg::LANE_STEP;
         end
         S_FR1: begin
            if (!is_short) begin
               back_a = wse_pkg::PAIR_BYTES;
               back_b = wse_pkg::LANE_STEP;
            end else if (short_len >= 5'd4) begin
               back_a = BW'(short_len);
               back_b = BW'(short_len - short_q);
            end else begin
               back_a = BW'(short_len);
               back_b = BW'(short_len - (short_len >> 1));
            end
         end
         S_FR2: begin
            if (is_short && short_len >= 5'd4) begin
               back_a = BW'(4);
               back_b = BW'(5'd4 + short_q);
            end else begin
               back_a = BW'(1);
               back_b = BW'(1);
            end
         end
         default: begin
            back_a = '0;
            back_b = '0;
         end
      endcase
      start_a = win_start(wr_ptr_ff, back_a);
      start_b = win_start(wr_ptr_ff, back_b);
   end

   // Bank write and read controls.
   always_comb begin
      logic [2:0] j;
      for (int k = 0; k < wse_pkg::WORD_BYTES; k++) begin
         j            = 3'(k) - wr_ptr_ff[2:0];
         bank_we[k]   = (state_ff == S_WRITE) && ({1'b0, j} < cur_ff.byte_count);
         bank_wa[k]   = bank_addr(wr_ptr_ff, 3'(k));
         bank_wd[k]   = cur_ff.data_word[{j, 3'b000} +: 8];
         bank_ra_a[k] = bank_addr(start_a, 3'(k));
         bank_ra_b[k] = bank_addr(start_b, 3'(k));
      end
   end

   for (genvar k = 0; k < wse_pkg::WORD_BYTES; k++) begin : g_bank
      logic [7:0] mem [DEPTH];
      always_ff @(posedge clock) begin
         if (bank_we[k]) begin
            mem[bank_wa[k]] <= bank_wd[k];
         end
         rd_a_ff[k] <= mem[bank_ra_a[k]];
         rd_b_ff[k] <= mem[bank_ra_b[k]];
      end
   end

   always_ff @(posedge clock) begin
      rot_a_ff <= start_a[2:0];
      rot_b_ff <= start_b[2:0];
   end

   // Undo the bank rotation so the first byte lands in the low bits.
   always_comb begin
      logic [2:0] ia;
      logic [2:0] ib;
      for (int j = 0; j < wse_pkg::WORD_BYTES; j++) begin
         ia = 3'(j) + rot_a_ff;
         ib = 3'(j) + rot_b_ff;
         rdata_a[8*j +: 8] = rd_a_ff[ia];
         rdata_b[8*j +: 8] = rd_b_ff[ib];
      end
   end

   // Operands of the first final mix.
   always_comb begin
      if (!is_short) begin
         fin_a = hold_a_ff;
         fin_b = hold_b_ff;
      end else if (short_len >= 5'd4) begin
         fin_a = {hold_a_ff[31:0], hold_b_ff[31:0]};
         fin_b = {rdata_a[31:0], rdata_b[31:0]};
      end else if (short_len != 5'd0) begin
         fin_a = {40'd0, hold_a_ff[7:0], hold_b_ff[7:0], rdata_a[7:0]};
         fin_b = '0;
      end else begin
         fin_a = '0;
         fin_b = '0;
      end
   end

   assign wr_sum   = {1'b0, wr_ptr_ff} + (PTR_W+1)'(cur_ff.byte_count);
   assign pend_sum = pend_ff + BW'(cur_ff.byte_count);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_in       = pend_ff;
      len_in        = len_ff;
      err_in        = err_ff;
      chunk_in      = chunk_ff;
      main_seed_in  = main_seed_ff;
      lane1_seed_in = lane1_seed_ff;
      lane2_seed_in = lane2_seed_ff;
      lane_in       = lane_ff;
      tail_back_in  = tail_back_ff;
      hold_a_in     = hold_a_ff;
      hold_b_in     = hold_b_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hash_in   = rsp_hash_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_err_in    = rsp_err_ff;
      item_pop      = 1'b0;
      mix_req.start = 1'b0;
      mix_req.a     = '0;
      mix_req.b     = '0;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_ptr_in = (wr_sum >= (PTR_W+1)'(WINDOW_BYTES))
                        ? PTR_W'(wr_sum - (PTR_W+1)'(WINDOW_BYTES)) : wr_sum[PTR_W-1:0];
            pend_in   = pend_sum;
            len_in    = len_ff + 64'(cur_ff.byte_count);
            err_in    = err_ff || cur_ff.short_word;
            lane_in   = '0;
            if (pend_sum > wse_pkg::CHUNK_BYTES) begin
               state_in = S_CHK_RD;
            end else if (cur_ff.last_word) begin
               state_in = S_FIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CHK_RD: begin
            state_in = S_CHK_GO;
         end
         S_CHK_GO: begin
            mix_req.start = 1'b1;
            case (lane_ff)
               2'd0: begin
                  mix_req.a = rdata_a ^ wse_pkg::SEC1;
                  mix_req.b = rdata_b ^ main_seed_ff;
               end
               2'd1: begin
                  mix_req.a = rdata_a ^ wse_pkg::SEC2;
                  mix_req.b = rdata_b ^ lane1_seed_ff;
               end
               default: begin
                  mix_req.a = rdata_a ^ wse_pkg::SEC3;
                  mix_req.b = rdata_b ^ lane2_seed_ff;
               end
            endcase
            state_in = S_CHK_WAIT;
         end
         S_CHK_WAIT: begin
            if (mix_rsp.done) begin
               case (lane_ff)
                  2'd0:    main_seed_in  = mix_rsp.value;
                  2'd1:    lane1_seed_in = mix_rsp.value;
                  default: lane2_seed_in = mix_rsp.value;
               endcase
               if (lane_ff == 2'd2) begin
                  pend_in  = pend_ff - wse_pkg::CHUNK_BYTES;
                  chunk_in = 1'b1;
                  state_in = cur_ff.last_word ? S_FIN : S_IDLE;
               end else begin
                  lane_in  = lane_ff + 2'd1;
                  state_in = S_CHK_RD;
               end
            end
         end
         S_FIN: begin
            if (!is_short) begin
               if (chunk_ff) begin
                  main_seed_in = main_seed_ff ^ lane1_seed_ff ^ lane2_seed_ff;
               end
               tail_back_in = pend_ff;
               state_in     = S_TAIL_RD;
            end else begin
               state_in = S_FR1;
            end
         end
         S_TAIL_RD: begin
            state_in = (tail_back_ff > wse_pkg::PAIR_BYTES) ? S_TAIL_GO : S_FR1;
         end
         S_TAIL_GO: begin
            mix_req.start = 1'b1;
            mix_req.a     = rdata_a ^ wse_pkg::SEC1;
            mix_req.b     = rdata_b ^ main_seed_ff;
            state_in      = S_TAIL_WAIT;
         end
         S_TAIL_WAIT: begin
            if (mix_rsp.done) begin
               main_seed_in = mix_rsp.value;
               tail_back_in = tail_back_ff - wse_pkg::PAIR_BYTES;
               state_in     = S_TAIL_RD;
            end
         end
         S_FR1: begin
            state_in = S_FR2;
         end
         S_FR2: begin
            hold_a_in = rdata_a;
            hold_b_in = rdata_b;
            state_in  = S_FR3;
         end
         S_FR3: begin
            mix_req.start = 1'b1;
            mix_req.a     = fin_a ^ wse_pkg::SEC1;
            mix_req.b     = fin_b ^ main_seed_ff;
            state_in      = S_MUL1_WAIT;
         end
         S_MUL1_WAIT: begin
            if (mix_rsp.done) begin
               mix_req.start = 1'b1;
               mix_req.a     = wse_pkg::SEC1 ^ len_ff;
               mix_req.b     = mix_rsp.value;
               state_in      = S_MUL2_WAIT;
            end
         end
         S_MUL2_WAIT: begin
            if (mix_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_hash_in   = mix_rsp.value;
               rsp_len_in    = len_ff;
               rsp_err_in    = err_ff;
               wr_ptr_in     = '0;
               pend_in       = '0;
               len_in        = '0;
               err_in        = 1'b0;
               chunk_in      = 1'b0;
               main_seed_in  = wse_pkg::SEC0;
               lane1_seed_in = wse_pkg::SEC0;
               lane2_seed_in = wse_pkg::SEC0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      tail_back_ff <= tail_back_in;
      hold_a_ff    <= hold_a_in;
      hold_b_ff    <= hold_b_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wr_ptr_ff     <= '0;
         pend_ff       <= '0;
         len_ff        <= '0;
         err_ff        <= 1'b0;
         chunk_ff      <= 1'b0;
         main_seed_ff  <= wse_pkg::SEC0;
         lane1_seed_ff <= wse_pkg::SEC0;
         lane2_seed_ff <= wse_pkg::SEC0;
         lane_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         pend_ff       <= pend_in;
         len_ff        <= len_in;
         err_ff        <= err_in;
         chunk_ff      <= chunk_in;
         main_seed_ff  <= main_seed_in;
         lane1_seed_ff <= lane1_seed_in;
         lane2_seed_ff <= lane2_seed_in;
         lane_ff       <= lane_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

/* rtl/wyhash_stream_engine_top.sv */
// Top level of the wyhash stream engine: front end, shared mix unit and back end.
`timescale 1ns / 1ps

// The engine hashes a byte message, delivered as little-endian 64-bit words, with a
// wyhash variant whose seed starts at the first secret constant. Each req transfer
// carries one word with its byte count (counts above eight act as eight) and a last
// flag; only the word flagged last produces a rsp transfer, which returns the hash,
// the total byte count and a format error bit that is set when a word short of eight
// bytes arrived before the last one. The back end picks an ordinary word off the
// two-entry input queue and then writes it into the 64-byte window. Whenever more
// than 48 bytes are pending since the chunk start, the chunk runs three lane mixes
// in turn, because all mixes share a single multiplier that builds each 64x64
// product from four 32x32 partial products. The last word adds the tail: up to two
// further 16-byte mixes, two window reads and the two final mixes before the
// result appears. The queue keeps req flowing while the back end works, and the
// result register lets the next message start while a finished hash waits on
// rsp_stall.

module wyhash_stream_engine_top #(
   parameter int WINDOW_BYTES = wse_pkg::WINDOW_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   output logic [63:0] rsp_message_length,
   output logic        rsp_format_error
);

   wse_pkg::item_type    item;
   logic                 item_valid;
   logic                 item_pop;
   wse_pkg::mix_req_type mix_req;
   wse_pkg::mix_rsp_type mix_rsp;

   // Front end: takes each transfer and classifies it into the queue.
   wse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   // The one multiplier, used for chunk lanes, tail pairs and the final mixes.
   wse_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .mix_req (mix_req),
      .mix_rsp (mix_rsp)
   );

   // Back end: window, message state, sequencing and the result register.
   wse_back #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .mix_req            (mix_req),
      .mix_rsp            (mix_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hash_value     (rsp_hash_value),
      .rsp_message_length (rsp_message_length),
      .rsp_format_error   (rsp_format_error)
   );

endmodule

/* rtl/wse_checker.sv */
// Port-level checker for the wyhash stream engine and its bind to the top level.
`timescale 1ns / 1ps

module wse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_word,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash_value,
   input logic [63:0] rsp_message_length,
   input logic        rsp_format_error
);

   logic [3:0] open_ff;
   logic       last_xfer;
   logic       rsp_xfer;

   assign last_xfer = req_valid && !req_stall && req_last_word;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // Messages whose last word went in and whose hash has not yet gone out.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 4'(last_xfer) - 4'(rsp_xfer);
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 4'd0))
      else $error("result without a finished message");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hash_value) && $stable(rsp_message_length)
                                 && $stable(rsp_format_error))
      else $error("result payload changed while stalled");

endmodule

bind wyhash_stream_engine_top wse_checker u_wse_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_last_word      (req_last_word),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_hash_value     (rsp_hash_value),
   .rsp_message_length (rsp_message_length),
   .rsp_format_error   (rsp_format_error)
);

/* bench/tb_wyhash_stream_engine_top.sv */
// Self-checking testbench for the wyhash stream engine top level.
`timescale 1ns / 1ps

// The testbench feeds messages of little-endian words into the engine. A local hash predictor
// keeps its own message state, in the same form as the engine's. It computes the expected
// result for each word flagged last. The directed part covers empty and short messages and
// the length boundaries around 4, 16, 48 and 64 bytes. It also covers byte counts above
// eight, short words before the last one, and all-zero and all-one data. The random part
// sends mostly well-formed messages with random lengths, and some malformed ones mixed in.
// Both sides pause in random bursts. At one point the sender holds off until every expected
// hash has arrived.

module tb_wyhash_stream_engine_top;

   typedef struct {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_word;
   } word_xfer_type;

   typedef struct {
      logic [63:0] hash_value;
      logic [63:0] message_length;
      logic        format_error;
   } hash_result_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_data_word;
   logic [3:0]  req_byte_count;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_hash_value;
   logic [63:0] rsp_message_length;
   logic        rsp_format_error;

   wyhash_stream_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_word(req_data_word), .req_byte_count(req_byte_count),
      .req_last_word(req_last_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hash_value(rsp_hash_value), .rsp_message_length(rsp_message_length),
      .rsp_format_error(rsp_format_error)
   );

   // Predictor state for the message that is currently being hashed.
   logic [63:0] seed_main, seed_lane1, seed_lane2, byte_total;
   logic [7:0]  window_bytes [wse_pkg::WINDOW_BYTES];
   logic        chunk_ran, short_seen;
   int unsigned window_ptr, pending_bytes;

   // These are the words that wait to be driven, and the hashes that are predicted but have
   // not arrived yet.
   word_xfer_type   pending_words[$];
   hash_result_type expected_hashes[$];

   int  error_count = 0;
   int  watchdog = 0;
   bit  stimulus_done = 0;
   bit  quiet_phase = 0;
   bit  hold_sender = 0;
   int  send_gap = 0;
   int  stall_gap = 0;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [63:0] mix64(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] product;
      product = {64'd0, a} * {64'd0, b};
      return product[63:0] ^ product[127:64];
   endfunction

   // This reads n bytes, little-endian, starting 'back' bytes behind the write pointer.
   function automatic logic [63:0] window_read(input int unsigned back, input int unsigned n);
      logic [63:0] value;
      value = '0;
      for (int j = 0; j < n && j < 8; j++)
         value[8*j +: 8] = window_bytes[(window_ptr + wse_pkg::WINDOW_BYTES - back + j)
                                        % wse_pkg::WINDOW_BYTES];
      return value;
   endfunction

   task automatic clear_message_state();
      seed_main = wse_pkg::SEC0;
      seed_lane1 = wse_pkg::SEC0;
      seed_lane2 = wse_pkg::SEC0;
      for (int k = 0; k < wse_pkg::WINDOW_BYTES; k++)
         window_bytes[k] = 8'd0;
      byte_total = '0;
      chunk_ran = 1'b0;
      short_seen = 1'b0;
      window_ptr = 0;
      pending_bytes = 0;
   endtask

   function automatic logic [63:0] finish_hash();
      logic [63:0] seed, a, b;
      int unsigned len, q, rest, off;
      seed = seed_main;
      if (byte_total <= 64'd16) begin
         len = byte_total[4:0];
         if (len >= 4) begin
            q = (len >> 3) << 2;
            a = (window_read(len, 4) << 32) | window_read(len - q, 4);
            b = (window_read(4, 4) << 32) | window_read(4 + q, 4);
         end else if (len > 0) begin
            a = (window_read(len, 1) << 16) | (window_read(len - (len >> 1), 1) << 8)
                | window_read(1, 1);
            b = '0;
         end else begin
            a = '0;
            b = '0;
         end
      end else begin
         rest = pending_bytes;
         off = 0;
         if (chunk_ran)
            seed ^= seed_lane1 ^ seed_lane2;
         while (rest > 16) begin
            seed = mix64(window_read(pending_bytes - off, 8) ^ wse_pkg::SEC1,
                         window_read(pending_bytes - off - 8, 8) ^ seed);
            rest -= 16;
            off += 16;
         end
         a = window_read(16, 8);
         b = window_read(8, 8);
      end
      return mix64(wse_pkg::SEC1 ^ byte_total, mix64(a ^ wse_pkg::SEC1, b ^ seed));
   endfunction

   // This takes one accepted word into the predictor. A word flagged last also pushes the
   // expected hash for the message.
   task automatic absorb_word(input word_xfer_type w);
      int unsigned n, p;
      hash_result_type r;
      n = (w.byte_count > 4'd8) ? 8 : w.byte_count;
      if (!w.last_word && n < 8)
         short_seen = 1'b1;
      for (int i = 0; i < n; i++) begin
         window_bytes[window_ptr] = w.data_word[8*i +: 8];
         window_ptr = (window_ptr + 1) % wse_pkg::WINDOW_BYTES;
         pending_bytes++;
         byte_total++;
      end
      if (pending_bytes > 48) begin
         p = pending_bytes;
         seed_main = mix64(window_read(p, 8) ^ wse_pkg::SEC1,
                           window_read(p - 8, 8) ^ seed_main);
         seed_lane1 = mix64(window_read(p - 16, 8) ^ wse_pkg::SEC2,
                            window_read(p - 24, 8) ^ seed_lane1);
         seed_lane2 = mix64(window_read(p - 32, 8) ^ wse_pkg::SEC3,
                            window_read(p - 40, 8) ^ seed_lane2);
         pending_bytes -= 48;
         chunk_ran = 1'b1;
      end
      if (w.last_word) begin
         r.hash_value = finish_hash();
         r.message_length = byte_total;
         r.format_error = short_seen;
         expected_hashes.push_back(r);
         clear_message_state();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // This queues one message. It has 'full_words' full words and then a last word carrying
   // 'tail_count' bytes. The tail count may also be above eight.
   task automatic queue_message(input int full_words, input int tail_count);
      word_xfer_type w;
      for (int i = 0; i < full_words; i++) begin
         w.data_word = random_word();
         w.byte_count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) : 4'd8;
         w.last_word = 1'b0;
         pending_words.push_back(w);
      end
      w.data_word = random_word();
      w.byte_count = 4'(tail_count);
      w.last_word = 1'b1;
      pending_words.push_back(w);
   endtask

   // Driver: the head of the pending queue is the word on the port; it leaves the queue
   // only after its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_word('{req_data_word, req_byte_count, req_last_word});
            void'(pending_words.pop_front());
         end
         if (req_valid && req_stall) begin
            // A stalled word stays on the port unchanged.
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (hold_sender || pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(0, 14);
         end else begin
            req_valid <= 1'b1;
            req_data_word <= pending_words[0].data_word;
            req_byte_count <= pending_words[0].byte_count;
            req_last_word <= pending_words[0].last_word;
         end
      end
   end

   // Monitor: this checks each hash transfer against the oldest expected hash. It also
   // drives random stall bursts on the result side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $display("unexpected hash transfer %h at %0t", rsp_hash_value, $realtime);
               error_count++;
            end else begin
               if (rsp_hash_value !== expected_hashes[0].hash_value)
                  report_mismatch("hash_value", rsp_hash_value, expected_hashes[0].hash_value);
               if (rsp_message_length !== expected_hashes[0].message_length)
                  report_mismatch("message_length", rsp_message_length,
                                  expected_hashes[0].message_length);
               if (rsp_format_error !== expected_hashes[0].format_error)
                  report_mismatch("format_error", 64'(rsp_format_error),
                                  64'(expected_hashes[0].format_error));
               void'(expected_hashes.pop_front());
            end
         end
         if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            stall_gap <= stall_gap - 1;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            stall_gap <= $urandom_range(0, 14);
         end else begin
            rsp_stall <= 1'b0;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (!req_valid && expected_hashes.size() == 0 && !stimulus_done))
            watchdog <= 0;
         else
            watchdog <= watchdog + 1;
      end
   end

   always @(posedge clock) begin
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d hashes outstanding", expected_hashes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int total_words;
      word_xfer_type w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_byte_count = '0;
      req_last_word = 1'b0;
      rsp_stall = 1'b0;
      clear_message_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty and short messages, and the tail pattern boundaries.
      queue_message(0, 0);
      queue_message(0, 1);
      queue_message(0, 3);
      queue_message(0, 4);
      queue_message(0, 8);
      queue_message(1, 8);
      queue_message(2, 0);
      queue_message(2, 1);
      queue_message(5, 8);
      queue_message(6, 1);
      queue_message(7, 8);
      queue_message(0, 15);
      // A short word that is not last sets the format error, and so does a zero count.
      w.data_word = '1;
      w.byte_count = 4'd3;
      w.last_word = 1'b0;
      pending_words.push_back(w);
      w.byte_count = 4'd0;
      pending_words.push_back(w);
      queue_message(0, 5);

      // The sender holds off until every hash has come back.
      wait (pending_words.size() == 0 && !req_valid);
      hold_sender = 1'b1;
      wait (expected_hashes.size() == 0);
      @(posedge clock);
      hold_sender <= 1'b0;

      // Random part: mostly well-formed messages, with a few malformed words mixed in.
      total_words = 0;
      while (total_words < 850) begin
         if ($urandom_range(0, 15) == 0) begin
            w.data_word = random_word();
            w.byte_count = 4'($urandom_range(0, 7));
            w.last_word = 1'b0;
            pending_words.push_back(w);
            total_words++;
         end
         if ($urandom_range(0, 7) == 0) begin
            // Longer messages run several chunks and wrap the window.
            queue_message($urandom_range(8, 30), $urandom_range(0, 15));
            total_words += 20;
         end else begin
            queue_message($urandom_range(0, 8), $urandom_range(0, 15));
            total_words += 5;
         end
         if (total_words > 700)
            quiet_phase = 1'b1;
         wait (pending_words.size() < 40);
      end

      wait (pending_words.size() == 0 && !req_valid);
      stimulus_done = 1'b1;
      wait (expected_hashes.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
